>>> design/ctt_pkg.sv
`default_nettype none

package ctt_pkg;

  // event codes on the result channel
  typedef enum logic [2:0] {
    EV_CHAR   = 3'd0,
    EV_WEND   = 3'd1,
    EV_LBRACE = 3'd2,
    EV_RBRACE = 3'd3,
    EV_SEP    = 3'd4,
    EV_END    = 3'd5
  } ev_t;

  // one result beat
  typedef struct packed {
    ev_t         ev;
    logic [7:0]  ch;
    logic [15:0] ts;
    logic [15:0] te;
    logic        last;
  } res_t;

  // all results caused by one input beat, in order, slot 0 first
  typedef struct packed {
    logic [1:0]      cnt;
    res_t [2:0]      slot;
  } batch_t;

  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_NL   = 8'h0A;
  localparam logic [7:0] CH_VT   = 8'h0B;
  localparam logic [7:0] CH_FF   = 8'h0C;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_DQ   = 8'h22;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_SQ   = 8'h27;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_BSL  = 8'h5C;
  localparam logic [7:0] CH_N    = 8'h6E;
  localparam logic [7:0] CH_T    = 8'h74;
  localparam logic [7:0] CH_LBR  = 8'h7B;
  localparam logic [7:0] CH_RBR  = 8'h7D;

endpackage

`default_nettype wire

>>> design/ctt_lexer.sv
`default_nettype none

module ctt_lexer import ctt_pkg::*; #(
  parameter int OFFSET_BITS = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       acc,
  input  wire logic [7:0] text_byte,
  input  wire logic       end_of_text,
  output batch_t          batch
);

  localparam int EXT_W = OFFSET_BITS + 16;

  typedef logic [OFFSET_BITS-1:0] off_t;

  typedef enum logic [2:0] {
    M_BETWEEN = 3'd0,
    M_BSLASH  = 3'd1,
    M_HASH    = 3'd2,
    M_COMMENT = 3'd3,
    M_BARE    = 3'd4,
    M_QUOTED  = 3'd5,
    M_QESC    = 3'd6
  } mode_t;

  typedef struct packed {
    logic  v;
    res_t  r;
    mode_t m;
    logic  lht;
    off_t  cts;
    logic  qd;
  } btw_t;

  mode_t mode_r, mode_nxt;
  logic  lht_r, lht_nxt;
  off_t  off_r, off_nxt;
  off_t  cts_r, cts_nxt;
  logic  qd_r, qd_nxt;

  logic       eot;
  logic       bare_end;
  logic       run_bare;
  logic       run_btw;
  logic       lht_in;
  off_t       pi;
  btw_t       bw;
  logic [2:0] pv;
  res_t [2:0] pr;
  logic [1:0] n;
  logic [7:0] esc_ch;

  function automatic off_t sat_inc(input off_t v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic logic [15:0] lo16(input off_t v);
    logic [EXT_W-1:0] t;
    t = EXT_W'(v);
    return t[15:0];
  endfunction

  function automatic res_t mk(input ev_t ev, input logic [7:0] ch, input off_t s,
                              input off_t e);
    res_t r;
    r.ev   = ev;
    r.ch   = ch;
    r.ts   = lo16(s);
    r.te   = lo16(e);
    r.last = 1'b0;
    return r;
  endfunction

  // token dispatch from the between-tokens state
  function automatic btw_t between(input logic [7:0] b, input off_t p, input logic lht,
                                   input off_t cts, input logic qd);
    btw_t o;
    off_t pn;
    pn    = sat_inc(p);
    o.v   = 1'b0;
    o.r   = mk(EV_CHAR, CH_NUL, p, pn);
    o.m   = M_BETWEEN;
    o.lht = lht;
    o.cts = cts;
    o.qd  = qd;
    case (b) inside
      CH_SP, CH_TAB, CH_CR, CH_VT, CH_FF: begin
      end
      CH_BSL: begin
        o.cts = p;
        o.m   = M_BSLASH;
      end
      CH_HASH: begin
        o.cts = p;
        o.m   = lht ? M_HASH : M_COMMENT;
      end
      CH_NL, CH_SEMI: begin
        o.v = 1'b1;
        o.r = mk(EV_SEP, CH_NUL, p, pn);
        if (b == CH_NL) o.lht = 1'b0;
      end
      CH_LBR, CH_RBR: begin
        o.v   = 1'b1;
        o.lht = 1'b1;
        o.r   = mk((b == CH_LBR) ? EV_LBRACE : EV_RBRACE, CH_NUL, p, pn);
      end
      CH_DQ, CH_SQ: begin
        o.lht = 1'b1;
        o.cts = p;
        o.qd  = (b == CH_DQ);
        o.m   = M_QUOTED;
      end
      default: begin
        o.v   = 1'b1;
        o.lht = 1'b1;
        o.cts = p;
        o.r   = mk(EV_CHAR, b, p, pn);
        o.m   = M_BARE;
      end
    endcase
    return o;
  endfunction

  assign eot      = end_of_text || (text_byte == CH_NUL);
  assign pi       = sat_inc(off_r);
  assign bare_end = text_byte inside {CH_SP, CH_TAB, CH_NL, CH_CR, CH_VT, CH_FF,
                                      CH_SEMI, CH_LBR, CH_RBR};
  // a held backslash that turns into a word has already marked the line
  assign lht_in   = (mode_r == M_BSLASH) ? 1'b1 : lht_r;
  assign bw       = between(text_byte, off_r, lht_in, cts_r, qd_r);
  assign esc_ch   = (text_byte == CH_N) ? CH_NL :
                    (text_byte == CH_T) ? CH_TAB : text_byte;

  // slot 0: held prefix char, slot 1: word char or word end, slot 2: dispatch
  always_comb begin
    pv       = '0;
    pr       = '0;
    run_bare = 1'b0;
    run_btw  = 1'b0;
    mode_nxt = mode_r;
    lht_nxt  = lht_r;
    cts_nxt  = cts_r;
    qd_nxt   = qd_r;
    off_nxt  = pi;
    if (eot) begin
      mode_nxt = M_BETWEEN;
      lht_nxt  = 1'b0;
      cts_nxt  = '0;
      qd_nxt   = 1'b0;
      off_nxt  = '0;
      pv[2]    = 1'b1;
      pr[2]    = mk(EV_END, CH_NUL, off_r, off_r);
      unique case (mode_r)
        M_BSLASH, M_QESC: begin
          pv[0] = 1'b1;
          pr[0] = mk(EV_CHAR, CH_BSL, cts_r, off_r);
          pv[1] = 1'b1;
          pr[1] = mk(EV_WEND, CH_NUL, cts_r, off_r);
        end
        M_BARE, M_QUOTED: begin
          pv[1] = 1'b1;
          pr[1] = mk(EV_WEND, CH_NUL, cts_r, off_r);
        end
        default: begin
        end
      endcase
    end else begin
      unique case (mode_r)
        M_BSLASH: begin
          if (text_byte == CH_NL) begin
            mode_nxt = M_BETWEEN;
          end else begin
            lht_nxt  = 1'b1;
            pv[0]    = 1'b1;
            pr[0]    = mk(EV_CHAR, CH_BSL, cts_r, sat_inc(cts_r));
            run_bare = 1'b1;
          end
        end
        M_HASH: begin
          if (text_byte == CH_SP || text_byte == CH_TAB || text_byte == CH_HASH) begin
            mode_nxt = M_COMMENT;
          end else if (text_byte == CH_NL) begin
            run_btw = 1'b1;
          end else begin
            pv[0]    = 1'b1;
            pr[0]    = mk(EV_CHAR, CH_HASH, cts_r, sat_inc(cts_r));
            run_bare = 1'b1;
          end
        end
        M_COMMENT: begin
          if (text_byte == CH_NL) run_btw = 1'b1;
        end
        M_BARE: begin
          run_bare = 1'b1;
        end
        M_QUOTED: begin
          if (text_byte == (qd_r ? CH_DQ : CH_SQ)) begin
            pv[1]    = 1'b1;
            pr[1]    = mk(EV_WEND, CH_NUL, cts_r, pi);
            mode_nxt = M_BETWEEN;
          end else if (text_byte == CH_BSL && qd_r) begin
            mode_nxt = M_QESC;
          end else begin
            pv[1] = 1'b1;
            pr[1] = mk(EV_CHAR, text_byte, cts_r, pi);
          end
        end
        M_QESC: begin
          pv[1]    = 1'b1;
          pr[1]    = mk(EV_CHAR, esc_ch, cts_r, pi);
          mode_nxt = M_QUOTED;
        end
        default: begin
          run_btw = 1'b1;
        end
      endcase
      if (run_bare) begin
        pv[1] = 1'b1;
        if (bare_end) begin
          pr[1]   = mk(EV_WEND, CH_NUL, cts_r, off_r);
          run_btw = 1'b1;
        end else begin
          pr[1]    = mk(EV_CHAR, text_byte, cts_r, pi);
          mode_nxt = M_BARE;
        end
      end
      if (run_btw) begin
        pv[2]    = bw.v;
        pr[2]    = bw.r;
        mode_nxt = bw.m;
        lht_nxt  = bw.lht;
        cts_nxt  = bw.cts;
        qd_nxt   = bw.qd;
      end
    end
  end

  // pack the valid slots to the front and flag the final one
  always_comb begin
    n          = 2'd0;
    batch.slot = '0;
    for (int i = 0; i < 3; i++) begin
      if (pv[i]) begin
        batch.slot[n] = pr[i];
        n             = n + 2'd1;
      end
    end
    if (n != 2'd0) batch.slot[n - 2'd1].last = 1'b1;
    batch.cnt = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_BETWEEN;
      lht_r  <= 1'b0;
      off_r  <= '0;
      cts_r  <= '0;
      qd_r   <= 1'b0;
    end else if (acc) begin
      mode_r <= mode_nxt;
      lht_r  <= lht_nxt;
      off_r  <= off_nxt;
      cts_r  <= cts_nxt;
      qd_r   <= qd_nxt;
    end
  end

  a_eot_clears: assert property (@(posedge clk) disable iff (!rst_n)
    acc && eot |=> mode_r == M_BETWEEN && off_r == '0 && !lht_r)
    else $error("state not cleared after end of text");

  a_off_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    acc && !eot |=> off_r >= $past(off_r) && off_r != '0)
    else $error("offset went backwards or wrapped");

  a_hash_needs_line: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == M_HASH |-> lht_r)
    else $error("pending hash on a line without a token");

endmodule

`default_nettype wire

>>> design/ctt_outq.sv
`default_nettype none

module ctt_outq import ctt_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic load,
  input  batch_t    batch,
  output logic      room,
  output logic      head_valid,
  input  wire logic head_ready,
  output res_t      head
);

  logic [1:0] cnt_r;
  res_t [2:0] q_r;
  logic       pop;

  assign head_valid = (cnt_r != 2'd0);
  assign pop        = head_valid && head_ready;
  // free when empty, or once the final queued beat leaves in this cycle
  assign room       = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && head_ready);
  assign head       = q_r[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (load) begin
      cnt_r <= batch.cnt;
    end else if (pop) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q_r <= batch.slot;
    end else if (pop) begin
      q_r[0] <= q_r[1];
      q_r[1] <= q_r[2];
    end
  end

  a_single_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd1 |-> q_r[0].last)
    else $error("lone queued beat lacks last flag");

  a_multi_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 || cnt_r == 2'd3 |-> !q_r[0].last)
    else $error("last flag ahead of queued beats");

  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> cnt_r == 2'd0 || (cnt_r == 2'd1 && pop))
    else $error("load over undelivered beats");

endmodule

`default_nettype wire

>>> design/config_text_tokenizer.sv
// Streaming tokenizer for brace-structured configuration text.
// Input channel (in_valid/in_ready): one text byte per beat; in_end_of_text,
//   or a zero byte, marks the end of the text.
// Output channel (out_valid/out_ready): one tokenizer event per beat: word
//   character, word end, open brace, close brace, separator, end of text,
//   with start/end byte offsets (low 16 bits). out_last flags the final event
//   caused by an input byte; a byte may cause zero to three events.
// Latency: events of a byte appear at the output the cycle after the byte
//   is accepted (registered result queue).
// Throughput: one byte per cycle while each byte yields at most one event and
//   out_ready is high; a byte yielding more events occupies the output until
//   its last event is delivered, and the next byte is taken in that cycle. The
//   limit is the single output beat per cycle.
// Stalls: with out_ready low, the result queue holds its events; in_ready is
//   low while events of an earlier byte wait, except in the cycle the final
//   one of them is taken.
// Reset: rst_n (synchronous, active low) returns the lexer to between-tokens,
//   offset zero, and empties the result queue. End of text does the same to
//   the lexer state after emitting its events.
`default_nettype none

module config_text_tokenizer import ctt_pkg::*; #(
  parameter int OFFSET_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_text_byte,
  input  wire logic        in_end_of_text,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_event_res,
  output logic [7:0]       out_word_char,
  output logic [15:0]      out_token_start,
  output logic [15:0]      out_token_end,
  output logic             out_last
);

  logic   acc;
  logic   room;
  batch_t batch;
  res_t   head;

  assign in_ready = room;
  assign acc      = in_valid && room;

  // lexer state advances on each accepted byte; its events go to the queue
  ctt_lexer #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_lexer (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (acc),
    .text_byte   (in_text_byte),
    .end_of_text (in_end_of_text),
    .batch       (batch)
  );

  // up to three events per byte, delivered one beat at a time
  ctt_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (acc),
    .batch      (batch),
    .room       (room),
    .head_valid (out_valid),
    .head_ready (out_ready),
    .head       (head)
  );

  assign out_event_res   = head.ev;
  assign out_word_char   = head.ch;
  assign out_token_start = head.ts;
  assign out_token_end   = head.te;
  assign out_last        = head.last;

endmodule

`default_nettype wire
